[rtl/ptqs_pkg.sv]
// package for the priority task queue scheduler
// holds mode, priority and run-state codes and the cell control/status structs
// no dependencies
`default_nettype none

package ptqs_pkg;

	// operation codes carried in the mode field
	localparam logic [2:0] MODE_ENQUEUE  = 3'd0;
	localparam logic [2:0] MODE_DISPATCH = 3'd1;
	localparam logic [2:0] MODE_STARTED  = 3'd2;
	localparam logic [2:0] MODE_COMPLETE = 3'd3;
	localparam logic [2:0] MODE_CLEAR    = 3'd4;

	// priority codes, lower value wins
	localparam logic [1:0] PRIO_URGENT     = 2'd0;
	localparam logic [1:0] PRIO_ELEVATED   = 2'd1;
	localparam logic [1:0] PRIO_NORMAL     = 2'd2;
	localparam logic [1:0] PRIO_BACKGROUND = 2'd3;

	// run states, a valid task type maps onto the state of the same code
	localparam logic [2:0] TYPE_NONE  = 3'd0;
	localparam logic [2:0] RUN_IDLE   = 3'd0;
	localparam logic [2:0] RUN_POLL   = 3'd1;
	localparam logic [2:0] RUN_UPDATE = 3'd5;

	// control shared by every cell of the row
	typedef struct packed {
		logic       load_en;   // enqueue accepted, the tail cell loads
		logic       remove_en; // dispatch taken, cells from the pick onward shift
		logic [2:0] key_type;
		logic [1:0] key_prio;
		logic [1:0] min_prio;  // lowest priority code present, from the eval stage
	} cell_ctrl_t;

	// status handed back by each cell
	typedef struct packed {
		logic       type_match;
		logic [3:0] prio_present;
		logic       pick;
		logic [2:0] entry_type;
		logic [1:0] entry_prio;
	} cell_stat_t;

endpackage

`default_nettype wire

[rtl/ptqs_cell.sv]
// one queue cell of the scheduler row: a stored (type, priority) entry
// shifts toward the head on removal, loads when it is the tail slot
// depends on ptqs_pkg
`default_nettype none

module ptqs_cell (
	input  logic                  clk,
	input  ptqs_pkg::cell_ctrl_t  ctrl,
	input  logic                  occupied,
	input  logic                  at_tail,
	input  logic                  found_in,
	input  logic [2:0]            nb_type,
	input  logic [1:0]            nb_prio,
	output logic                  found_out,
	output ptqs_pkg::cell_stat_t  stat
);
	import ptqs_pkg::*;

	logic [2:0] type_q;
	logic [1:0] prio_q;
	logic       hit;

	assign hit       = occupied & (prio_q == ctrl.min_prio);
	assign found_out = found_in | hit;

	always_comb begin
		stat.type_match   = occupied & (type_q == ctrl.key_type);
		stat.prio_present = occupied ? 4'(4'b0001 << prio_q) : 4'b0000;
		stat.pick         = hit & ~found_in;
		stat.entry_type   = type_q;
		stat.entry_prio   = prio_q;
	end

	// entry payload, no reset: unread until written
	always_ff @(posedge clk) begin
		if (ctrl.remove_en && found_out) begin
			type_q <= nb_type;
			prio_q <= nb_prio;
		end else if (ctrl.load_en && at_tail) begin
			type_q <= ctrl.key_type;
			prio_q <= ctrl.key_prio;
		end
	end

endmodule

`default_nettype wire

[rtl/priority_task_queue_scheduler.sv]
// top level of the priority task queue scheduler: control sequencer, counters,
// output register and a row of ptqs_cell entries kept in arrival order
// depends on ptqs_pkg and ptqs_cell
`default_nettype none

// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   mode, task_type, task_priority
// out       source     out_valid/out_stall ok, duplicate, next_type, next_priority,
//                                          run_state_out, busy_res, update_allowed,
//                                          fill_level, dropped_total, completed_total
//
// an item passes an eval state, which reduces the row (duplicate and lowest
// priority present), then an apply state, which updates the row and loads the output register
// a new item is taken in the apply state as the result is registered, overlapping the last item
// reset clears fill, counters and run state; entries need no clearing pass
// a stalled output holds the sequencer in apply until the register frees

module priority_task_queue_scheduler #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  task_type,
	input  logic [1:0]  task_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic        duplicate,
	output logic [2:0]  next_type,
	output logic [1:0]  next_priority,
	output logic [2:0]  run_state_out,
	output logic        busy_res,
	output logic        update_allowed,
	output logic [3:0]  fill_level,
	output logic [31:0] dropped_total,
	output logic [31:0] completed_total
);
	import ptqs_pkg::*;

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_APPLY = 3'b100
	} seq_state_t;

	seq_state_t  state_q;
	logic        in_acc;
	logic        apply_fire;

	// captured item
	logic [2:0]  mode_q;
	logic [2:0]  type_q;
	logic [1:0]  prio_q;

	// eval stage results
	logic        dup_s1;
	logic [1:0]  min_prio_s1;

	// architectural state
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] crit_q;
	logic [2:0]        run_q;
	logic [31:0]       drop_q;
	logic [31:0]       done_q;

	// next values
	logic [FILL_W-1:0] fill_nxt;
	logic [FILL_W-1:0] crit_nxt;
	logic [2:0]        run_nxt;
	logic [31:0]       drop_nxt;
	logic [31:0]       done_nxt;
	logic              ok_nxt;
	logic              dup_nxt;
	logic [2:0]        ntype_nxt;
	logic [1:0]        nprio_nxt;
	logic              load_en;
	logic              remove_en;

	// output register
	logic              out_valid_q;
	logic              ok_q;
	logic              dup_q;
	logic [2:0]        ntype_q;
	logic [1:0]        nprio_q;
	logic [2:0]        run_out_q;
	logic              upd_q;
	logic [FILL_W-1:0] fill_out_q;

	// row of cells
	cell_ctrl_t        ctrl;
	cell_stat_t        stat [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] found;
	logic [2:0]        ent_type [QUEUE_DEPTH];
	logic [1:0]        ent_prio [QUEUE_DEPTH];
	logic              any_dup;
	logic [3:0]        prio_any;
	logic [2:0]        pick_type;

	// ---------------------------------------------------------------
	// handshake: take an item when idle, or in apply as the result leaves
	// ---------------------------------------------------------------
	assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || !out_stall);
	assign in_stall   = !((state_q == ST_IDLE) || apply_fire);
	assign in_acc     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_fire) state_q <= in_acc ? ST_EVAL : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			type_q <= task_type;
			prio_q <= task_priority;
		end
	end

	// ---------------------------------------------------------------
	// cell row: entry 0 is the oldest, occupancy follows the fill count
	// ---------------------------------------------------------------
	always_comb begin
		ctrl.load_en   = load_en;
		ctrl.remove_en = remove_en;
		ctrl.key_type  = type_q;
		ctrl.key_prio  = prio_q;
		ctrl.min_prio  = min_prio_s1;
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [2:0] nb_type;
		logic [1:0] nb_prio;

		// last cell shifts in its own value, which drops out of the fill anyway
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nb_type = ent_type[i];
			assign nb_prio = ent_prio[i];
		end else begin : g_mid
			assign nb_type = ent_type[i+1];
			assign nb_prio = ent_prio[i+1];
		end

		ptqs_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (FILL_W'(i) < fill_q),
			.at_tail   (FILL_W'(i) == fill_q),
			.found_in  (found[i]),
			.nb_type   (nb_type),
			.nb_prio   (nb_prio),
			.found_out (found[i+1]),
			.stat      (stat[i])
		);

		assign ent_type[i] = stat[i].entry_type;
		assign ent_prio[i] = stat[i].entry_prio;
	end

	// reductions over the row
	always_comb begin
		any_dup   = 1'b0;
		prio_any  = 4'b0000;
		pick_type = TYPE_NONE;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			any_dup   = any_dup | stat[k].type_match;
			prio_any  = prio_any | stat[k].prio_present;
			pick_type = pick_type | ({3{stat[k].pick}} & stat[k].entry_type);
		end
	end

	// eval stage: register duplicate flag and lowest priority code present
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			dup_s1 <= any_dup;
			if (prio_any[0])      min_prio_s1 <= PRIO_URGENT;
			else if (prio_any[1]) min_prio_s1 <= PRIO_ELEVATED;
			else if (prio_any[2]) min_prio_s1 <= PRIO_NORMAL;
			else                  min_prio_s1 <= PRIO_BACKGROUND;
		end
	end

	// ---------------------------------------------------------------
	// apply stage: next state and result fields
	// ---------------------------------------------------------------
	always_comb begin
		fill_nxt  = fill_q;
		crit_nxt  = crit_q;
		run_nxt   = run_q;
		drop_nxt  = drop_q;
		done_nxt  = done_q;
		ok_nxt    = 1'b1;
		dup_nxt   = 1'b0;
		ntype_nxt = TYPE_NONE;
		nprio_nxt = PRIO_BACKGROUND;
		load_en   = 1'b0;
		remove_en = 1'b0;
		case (mode_q)
			MODE_ENQUEUE: begin
				if (dup_s1) begin
					dup_nxt = 1'b1;
				end else if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
					drop_nxt = drop_q + 32'd1;
					ok_nxt   = 1'b0;
				end else begin
					load_en  = apply_fire;
					fill_nxt = fill_q + FILL_W'(1);
					if (prio_q == PRIO_URGENT) crit_nxt = crit_q + FILL_W'(1);
				end
			end
			MODE_DISPATCH: begin
				if (run_q != RUN_IDLE || fill_q == '0) begin
					ok_nxt = 1'b0;
				end else begin
					remove_en = apply_fire;
					fill_nxt  = fill_q - FILL_W'(1);
					ntype_nxt = pick_type;
					nprio_nxt = min_prio_s1;
					if (min_prio_s1 == PRIO_URGENT) crit_nxt = crit_q - FILL_W'(1);
				end
			end
			MODE_STARTED: begin
				case (type_q) inside
					[RUN_POLL:RUN_UPDATE]: run_nxt = type_q;
					default:               run_nxt = RUN_IDLE;
				endcase
			end
			MODE_COMPLETE: begin
				run_nxt  = RUN_IDLE;
				done_nxt = done_q + 32'd1;
			end
			MODE_CLEAR: begin
				fill_nxt = '0;
				crit_nxt = '0;
				run_nxt  = RUN_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crit_q <= '0;
			run_q  <= RUN_IDLE;
			drop_q <= '0;
			done_q <= '0;
		end else if (apply_fire) begin
			fill_q <= fill_nxt;
			crit_q <= crit_nxt;
			run_q  <= run_nxt;
			drop_q <= drop_nxt;
			done_q <= done_nxt;
		end
	end

	// output register, separates the item side from the result side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			ok_q       <= ok_nxt;
			dup_q      <= dup_nxt;
			ntype_q    <= ntype_nxt;
			nprio_q    <= nprio_nxt;
			run_out_q  <= run_nxt;
			upd_q      <= (run_nxt == RUN_IDLE) && (crit_nxt == '0);
			fill_out_q <= fill_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = ok_q;
	assign duplicate       = dup_q;
	assign next_type       = ntype_q;
	assign next_priority   = nprio_q;
	assign run_state_out   = run_out_q;
	assign busy_res        = (run_out_q != RUN_IDLE);
	assign update_allowed  = upd_q;
	assign fill_level      = 4'(fill_out_q);
	assign dropped_total   = drop_q;
	assign completed_total = done_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("fill count beyond queue depth");

	a_crit_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		crit_q <= fill_q)
		else $error("critical count exceeds fill");

	a_eval_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |=> state_q == ST_APPLY)
		else $error("eval not followed by apply");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_EVAL)
		else $error("accepted item not evaluated");

endmodule

`default_nettype wire
